// ===== sv/kts_pkg.sv =====
`timescale 1ns / 1ps

package kts_pkg;

  localparam int CAPACITY = 64;
  localparam int KEY_BITS = 16;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int TAG_W    = 8;
  localparam int KIND_W   = 3;
  localparam int STAT_W   = 2;
  localparam int MAX_W    = 17;

  localparam logic [KIND_W-1:0] KIND_ADD    = 3'd0;
  localparam logic [KIND_W-1:0] KIND_REMOVE = 3'd1;
  localparam logic [KIND_W-1:0] KIND_SET    = 3'd2;
  localparam logic [KIND_W-1:0] KIND_GET    = 3'd3;
  localparam logic [KIND_W-1:0] KIND_MAX    = 3'd4;

  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [STAT_W-1:0] ST_DUPLICATE = 2'd2;
  localparam logic [STAT_W-1:0] ST_FULL      = 2'd3;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_LAST,
    S_FINISH
  } state_t;

endpackage

// ===== sv/key_tag_set_table.sv =====
`timescale 1ns / 1ps

// Table of up to 64 distinct 16-bit keys with an 8-bit tag each, kept densely in
// slots 0..entry_count-1 of two synchronous RAMs, each with a read and a write
// port. One request is accepted at a time and gives exactly one result
// transfer. Every lookup walks the stored entries through the RAM read port,
// one entry per cycle, and stops early when the key is found; a successful
// remove also passes through S_LAST to read the last entry before it is moved
// into the freed slot. A new request is taken while the previous result still
// waits in the output register.

module key_tag_set_table (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [15:0] key_in, [23:16] tag_in
  input  logic [2:0]  in_tuser,   // [2:0] kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [7:0] tag_out, [24:8] max_key, [31:25] zero
  output logic [1:0]  out_tuser   // [1:0] status
);

  kts_pkg::state_t state_r, state_nxt;

  logic [kts_pkg::KEY_BITS-1:0] key_mem [kts_pkg::CAPACITY];
  logic [kts_pkg::TAG_W-1:0]    tag_mem [kts_pkg::CAPACITY];

  logic [kts_pkg::CNT_W-1:0]    count_r;
  logic [kts_pkg::CNT_W-1:0]    idx_r;
  logic [kts_pkg::KIND_W-1:0]   kind_r;
  logic [kts_pkg::KEY_BITS-1:0] key_r;
  logic [kts_pkg::TAG_W-1:0]    tag_r;
  logic [kts_pkg::KEY_BITS-1:0] key_rd_r;
  logic [kts_pkg::TAG_W-1:0]    tag_rd_r;
  logic                         pend_r;
  logic [kts_pkg::IDX_W-1:0]    pend_idx_r;
  logic                         found_r;
  logic [kts_pkg::IDX_W-1:0]    pos_r;
  logic [kts_pkg::TAG_W-1:0]    tag_hit_r;
  logic [kts_pkg::KEY_BITS-1:0] best_r;

  logic                         out_valid_r;
  logic [kts_pkg::STAT_W-1:0]   out_status_r;
  logic [kts_pkg::TAG_W-1:0]    out_tag_r;
  logic [kts_pkg::MAX_W-1:0]    out_max_r;

  logic                         accept;
  logic                         found_now;
  logic                         scan_done;
  logic                         issue;
  logic                         rd_en;
  logic [kts_pkg::IDX_W-1:0]    rd_addr;
  logic [kts_pkg::CNT_W-1:0]    last_cnt;
  logic                         fin_go;
  logic                         is_full;
  logic                         key_we;
  logic [kts_pkg::IDX_W-1:0]    key_waddr;
  logic [kts_pkg::KEY_BITS-1:0] key_wdata;
  logic                         tag_we;
  logic [kts_pkg::IDX_W-1:0]    tag_waddr;
  logic [kts_pkg::TAG_W-1:0]    tag_wdata;
  logic                         cnt_inc;
  logic                         cnt_dec;
  logic [kts_pkg::STAT_W-1:0]   res_status;
  logic [kts_pkg::TAG_W-1:0]    res_tag;
  logic [kts_pkg::MAX_W-1:0]    res_max;

  assign accept    = in_tvalid && in_tready;
  assign last_cnt  = kts_pkg::CNT_W'(count_r - kts_pkg::CNT_W'(1));
  assign is_full   = (count_r == kts_pkg::CNT_W'(kts_pkg::CAPACITY));
  assign found_now = (state_r == kts_pkg::S_SCAN) && pend_r && (key_rd_r == key_r) &&
                     (kind_r != kts_pkg::KIND_MAX);
  assign scan_done = found_now || ((idx_r == count_r) && !pend_r);
  assign issue     = (state_r == kts_pkg::S_SCAN) && (idx_r != count_r) && !found_now;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      kts_pkg::S_IDLE: begin
        if (in_tvalid) begin
          if (in_tuser inside {kts_pkg::KIND_ADD, kts_pkg::KIND_REMOVE, kts_pkg::KIND_SET,
                               kts_pkg::KIND_GET, kts_pkg::KIND_MAX}) begin
            state_nxt = kts_pkg::S_SCAN;
          end else begin
            state_nxt = kts_pkg::S_FINISH;
          end
        end
      end
      kts_pkg::S_SCAN: begin
        if (scan_done) begin
          if (found_now && (kind_r == kts_pkg::KIND_REMOVE)) begin
            state_nxt = kts_pkg::S_LAST;
          end else begin
            state_nxt = kts_pkg::S_FINISH;
          end
        end
      end
      kts_pkg::S_LAST: begin
        state_nxt = kts_pkg::S_FINISH;
      end
      kts_pkg::S_FINISH: begin
        if (fin_go) begin
          state_nxt = kts_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = kts_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    in_tready = 1'b0;
    rd_en     = 1'b0;
    rd_addr   = idx_r[kts_pkg::IDX_W-1:0];
    fin_go    = 1'b0;
    case (state_r)
      kts_pkg::S_IDLE: begin
        in_tready = 1'b1;
      end
      kts_pkg::S_SCAN: begin
        rd_en = issue;
      end
      kts_pkg::S_LAST: begin
        rd_en   = 1'b1;
        rd_addr = last_cnt[kts_pkg::IDX_W-1:0];
      end
      kts_pkg::S_FINISH: begin
        fin_go = !out_valid_r || out_tready;
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

  always_comb begin
    key_we     = 1'b0;
    key_waddr  = pos_r;
    key_wdata  = key_rd_r;
    tag_we     = 1'b0;
    tag_waddr  = pos_r;
    tag_wdata  = tag_rd_r;
    cnt_inc    = 1'b0;
    cnt_dec    = 1'b0;
    res_status = kts_pkg::ST_OK;
    res_tag    = '0;
    res_max    = '1;
    case (kind_r)
      kts_pkg::KIND_ADD: begin
        if (found_r) begin
          res_status = kts_pkg::ST_DUPLICATE;
        end else if (is_full) begin
          res_status = kts_pkg::ST_FULL;
        end else begin
          key_we    = fin_go;
          key_waddr = count_r[kts_pkg::IDX_W-1:0];
          key_wdata = key_r;
          tag_we    = fin_go;
          tag_waddr = count_r[kts_pkg::IDX_W-1:0];
          tag_wdata = '0;
          cnt_inc   = fin_go;
        end
      end
      kts_pkg::KIND_REMOVE: begin
        if (found_r) begin
          key_we  = fin_go;
          tag_we  = fin_go;
          cnt_dec = fin_go;
        end else begin
          res_status = kts_pkg::ST_NOT_FOUND;
        end
      end
      kts_pkg::KIND_SET: begin
        if (found_r) begin
          tag_we    = fin_go;
          tag_wdata = tag_r;
        end else begin
          res_status = kts_pkg::ST_NOT_FOUND;
        end
      end
      kts_pkg::KIND_GET: begin
        if (found_r) begin
          res_tag = tag_hit_r;
        end else begin
          res_status = kts_pkg::ST_NOT_FOUND;
        end
      end
      kts_pkg::KIND_MAX: begin
        if (count_r != '0) begin
          res_max = {1'b0, best_r};
        end
      end
      default: begin
        res_status = kts_pkg::ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[key_waddr] <= key_wdata;
    end
    if (tag_we) begin
      tag_mem[tag_waddr] <= tag_wdata;
    end
    if (rd_en) begin
      key_rd_r <= key_mem[rd_addr];
      tag_rd_r <= tag_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= kts_pkg::S_IDLE;
      count_r     <= '0;
      pend_r      <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= issue;
      if (cnt_inc) begin
        count_r <= kts_pkg::CNT_W'(count_r + kts_pkg::CNT_W'(1));
      end else if (cnt_dec) begin
        count_r <= last_cnt;
      end
      if (accept) begin
        found_r <= 1'b0;
      end else if (found_now) begin
        found_r <= 1'b1;
      end
      if (fin_go) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    pend_idx_r <= rd_addr;
    if (accept) begin
      kind_r <= in_tuser;
      key_r  <= in_tdata[kts_pkg::KEY_BITS-1:0];
      tag_r  <= in_tdata[23:16];
      idx_r  <= '0;
      best_r <= '0;
    end else begin
      if (issue) begin
        idx_r <= kts_pkg::CNT_W'(idx_r + kts_pkg::CNT_W'(1));
      end
      if ((state_r == kts_pkg::S_SCAN) && pend_r && (key_rd_r > best_r)) begin
        best_r <= key_rd_r;
      end
    end
    if (found_now) begin
      pos_r     <= pend_idx_r;
      tag_hit_r <= tag_rd_r;
    end
    if (fin_go) begin
      out_status_r <= res_status;
      out_tag_r    <= res_tag;
      out_max_r    <= res_max;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {7'd0, out_max_r, out_tag_r};

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= kts_pkg::CNT_W'(kts_pkg::CAPACITY))
    else $error("entry count above capacity");

  a_count_only_at_finish: assert property (@(posedge clk) disable iff (!rst_n)
    !$stable(count_r) |-> ($past(state_r) == kts_pkg::S_FINISH) && out_valid_r)
    else $error("entry count changed outside finish");

  a_found_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (found_r && (state_r == kts_pkg::S_FINISH)) |->
      (kts_pkg::CNT_W'(pos_r) < count_r))
    else $error("hit slot beyond entry count");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == kts_pkg::S_SCAN) |-> (idx_r <= count_r))
    else $error("scan index past entry count");

endmodule
